/* src/mpid_pkg.sv */
// Shared types and constants for the multichannel PID block.
`default_nettype none
package mpid_pkg;

   localparam int CHANNELS_DEF = 8;
   localparam int CH_CAP       = 8;
   localparam int ACC_W        = 98;
   localparam int DIV_W        = 96;
   localparam int MUL_W        = 35;
   localparam int PROD_W       = 2 * MUL_W;
   localparam logic [31:0] NS_SCALE = 32'd1000000000;
   // floor(2^62 / 1e9), reciprocal for the integral-term divide
   localparam logic [32:0] NS_RECIP = 33'd4611686018;

   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] CSR_GAIN_P        = 2'd1;
   localparam logic [1:0] CSR_GAIN_I        = 2'd2;
   localparam logic [1:0] CSR_GAIN_D        = 2'd3;

   typedef enum logic [2:0] {
      KIND_PROCESS  = 3'd0,
      KIND_SETPOINT = 3'd1,
      KIND_LIMITS   = 3'd2,
      KIND_ENABLE   = 3'd3,
      KIND_GAINS    = 3'd4,
      KIND_TICK     = 3'd5
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_MUL, ST_ACC, ST_DSTART, ST_DWAIT, ST_STORE, ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      STEP_INT, STEP_P, STEP_DIFF, STEP_DLO, STEP_DHI, STEP_ILO, STEP_IHI
   } step_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_WRITE, OP_TICK, OP_LOAD, OP_MUL, OP_ACC,
      OP_DIV_START, OP_DIV_TAKE, OP_STORE, OP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      RD_IDLE, RD_EST, RD_BACK, RD_FIX
   } rdiv_state_type;

   typedef struct packed {
      dp_op_type op;
      step_type  step;
   } cmd_type;

   typedef struct packed {
      logic enabled;
      logic ns_zero;
      logic div_busy;
      logic out_free;
      logic last;
      logic limit_zero;
   } status_type;

endpackage
`default_nettype wire

/* src/multichannel_pid_with_limit_alarms.sv */
// Top level of the multichannel PID controller with limit alarms.
// Usage:
//  - req_* channel (valid/ready): one transaction either writes a channel's
//    process value, setpoint, alarm limits, enable or gains, or is a tick
//    carrying elapsed nanoseconds in req_delta_ns. Kinds 6 and 7 are dropped.
//  - rsp_* channel (valid/ready): a tick yields one transaction per handled
//    channel (0 .. channel_count-1, capped at 8 and CHANNELS), rsp_last on
//    the final one.
//  - csr_* port: plain write of channel_count and the default gains.
// Operation:
//  - a write is stored as it is accepted; req_ready is high only in the idle state.
//  - an enabled channel makes seven passes through the shared 35x35
//    multiplier, one bit-serial divide of the derivative by ns and one
//    reciprocal divide of the integral term by 1e9; when ns is zero the
//    derivative passes and their divide are skipped. A disabled channel is
//    only loaded and emitted.
// Reset: stores but the gain table reset at once; no clearing pass.
// Stall: results sit in an output register; while it is full and rsp_ready
//  is low the sequencer holds in the emit step and resumes when it frees.
`default_nettype none
module multichannel_pid_with_limit_alarms #(
   parameter int CHANNELS = mpid_pkg::CHANNELS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_kind,
   input  wire logic [2:0]         req_channel,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_high_limit,
   input  wire logic               req_enable,
   input  wire logic signed [31:0] req_gain_p,
   input  wire logic signed [31:0] req_gain_i,
   input  wire logic signed [31:0] req_gain_d,
   input  wire logic [31:0]        req_delta_ns,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_result_channel,
   output logic signed [31:0]      rsp_drive_value,
   output logic                    rsp_alarm,
   output logic                    rsp_running,
   output logic                    rsp_last,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data
);
   mpid_pkg::cmd_type    cmd;
   mpid_pkg::status_type status;

   // sequencer
   mpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stores, arithmetic and result register
   mpid_dp #(
      .CHANNELS (CHANNELS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_channel        (req_channel),
      .req_kind           (req_kind),
      .req_value          (req_value),
      .req_high_limit     (req_high_limit),
      .req_enable         (req_enable),
      .req_gain_p         (req_gain_p),
      .req_gain_i         (req_gain_i),
      .req_gain_d         (req_gain_d),
      .req_delta_ns       (req_delta_ns),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_channel (rsp_result_channel),
      .rsp_drive_value    (rsp_drive_value),
      .rsp_alarm          (rsp_alarm),
      .rsp_running        (rsp_running),
      .rsp_last           (rsp_last)
   );
endmodule
`default_nettype wire

/* src/mpid_div.sv */
// Dividers: bit-serial by a variable divisor, and reciprocal-multiply by 1e9.
`default_nettype none
module mpid_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mpid_pkg::DIV_W-1:0]    dividend,
   input  wire logic [31:0]                   divisor,
   output logic                               busy,
   output logic [mpid_pkg::DIV_W-1:0]         quotient
);
   localparam int CNT_W = $clog2(mpid_pkg::DIV_W + 1);

   logic [CNT_W-1:0]           count_ff, count_in;
   logic [mpid_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [31:0]                rem_ff, rem_in;
   logic [31:0]                div_ff, div_in;
   logic [32:0]                shifted, trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[mpid_pkg::DIV_W-1]};
      trial    = shifted - {1'b0, div_ff};
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         count_in = CNT_W'(mpid_pkg::DIV_W);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[mpid_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[mpid_pkg::DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = (count_ff != '0);
   assign quotient = quo_ff;
endmodule

// 32 quotient bits per limb: estimate with the reciprocal, multiply back,
// then fix up by at most three subtractions of 1e9.
module mpid_rdiv (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [mpid_pkg::DIV_W-1:0]    dividend,
   output logic                               busy,
   output logic [mpid_pkg::DIV_W-1:0]         quotient
);
   localparam int          DW    = mpid_pkg::DIV_W;
   localparam int          LIMBS = DW / 32;
   localparam logic [32:0] D1    = 33'(mpid_pkg::NS_SCALE);
   localparam logic [32:0] D2    = D1 + D1;
   localparam logic [32:0] D3    = D2 + D1;

   mpid_pkg::rdiv_state_type state_ff, state_in;
   logic [1:0]    limb_ff, limb_in;
   logic [DW-1:0] num_ff, num_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [29:0]   rem_ff, rem_in;
   logic [31:0]   qe_ff, qe_in;
   logic [32:0]   diff_ff, diff_in;
   logic [61:0]   cur, back_prod, diff_sub;
   logic [64:0]   est_prod;
   logic [31:0]   qfix;
   logic [32:0]   rfix;

   always_comb begin
      cur       = {rem_ff, num_ff[DW-1 -: 32]};
      est_prod  = 65'(cur[61:30]) * 65'(mpid_pkg::NS_RECIP);
      back_prod = 62'(qe_ff) * 62'(mpid_pkg::NS_SCALE);
      diff_sub  = cur - back_prod;
      if (diff_ff >= D3) begin
         qfix = qe_ff + 32'd3;
         rfix = diff_ff - D3;
      end else if (diff_ff >= D2) begin
         qfix = qe_ff + 32'd2;
         rfix = diff_ff - D2;
      end else if (diff_ff >= D1) begin
         qfix = qe_ff + 32'd1;
         rfix = diff_ff - D1;
      end else begin
         qfix = qe_ff;
         rfix = diff_ff;
      end

      state_in = state_ff;
      limb_in  = limb_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      qe_in    = qe_ff;
      diff_in  = diff_ff;
      case (state_ff)
         mpid_pkg::RD_IDLE: ;
         mpid_pkg::RD_EST: begin
            qe_in    = est_prod[63:32];
            state_in = mpid_pkg::RD_BACK;
         end
         mpid_pkg::RD_BACK: begin
            diff_in  = diff_sub[32:0];
            state_in = mpid_pkg::RD_FIX;
         end
         mpid_pkg::RD_FIX: begin
            quo_in   = {quo_ff[DW-33:0], qfix};
            rem_in   = rfix[29:0];
            num_in   = {num_ff[DW-33:0], 32'b0};
            limb_in  = limb_ff + 2'd1;
            state_in = (limb_ff == 2'(LIMBS - 1)) ? mpid_pkg::RD_IDLE : mpid_pkg::RD_EST;
         end
         default: state_in = mpid_pkg::RD_IDLE;
      endcase
      if (start) begin
         state_in = mpid_pkg::RD_EST;
         limb_in  = '0;
         num_in   = dividend;
         quo_in   = '0;
         rem_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpid_pkg::RD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      limb_ff <= limb_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      qe_ff   <= qe_in;
      diff_ff <= diff_in;
   end

   assign busy     = (state_ff != mpid_pkg::RD_IDLE);
   assign quotient = quo_ff;
endmodule
`default_nettype wire

/* src/mpid_dp.sv */
// Datapath: channel stores, shared multiplier, dividers, accumulator, result register.
`default_nettype none
module mpid_dp #(
   parameter int CHANNELS = mpid_pkg::CHANNELS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mpid_pkg::cmd_type  cmd,
   output mpid_pkg::status_type    status,
   input  wire logic [2:0]         req_channel,
   input  wire logic [2:0]         req_kind,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_high_limit,
   input  wire logic               req_enable,
   input  wire logic signed [31:0] req_gain_p,
   input  wire logic signed [31:0] req_gain_i,
   input  wire logic signed [31:0] req_gain_d,
   input  wire logic [31:0]        req_delta_ns,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [2:0]              rsp_result_channel,
   output logic signed [31:0]      rsp_drive_value,
   output logic                    rsp_alarm,
   output logic                    rsp_running,
   output logic                    rsp_last
);
   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CAP   = (CHANNELS < mpid_pkg::CH_CAP) ? CHANNELS : mpid_pkg::CH_CAP;
   localparam int ACC_W = mpid_pkg::ACC_W;
   localparam int DIV_W = mpid_pkg::DIV_W;
   localparam int MUL_W = mpid_pkg::MUL_W;
   localparam int PROD_W = mpid_pkg::PROD_W;

   // configuration
   logic [3:0]         count_ff;
   logic signed [31:0] dkp_ff, dki_ff, dkd_ff;

   // channel stores
   logic signed [31:0] pv_ff   [CHANNELS];
   logic signed [31:0] sp_ff   [CHANNELS];
   logic signed [31:0] drv_ff  [CHANNELS];
   logic signed [63:0] integ_ff[CHANNELS];
   logic signed [32:0] prev_ff [CHANNELS];
   logic               en_ff   [CHANNELS];
   logic signed [31:0] lo_ff   [CHANNELS];
   logic signed [31:0] hi_ff   [CHANNELS];
   logic signed [31:0] gp_ff   [CHANNELS];
   logic signed [31:0] gi_ff   [CHANNELS];
   logic signed [31:0] gd_ff   [CHANNELS];
   logic               gl_ff   [CHANNELS];

   // working registers
   logic [3:0]               ch_ff, limit_ff;
   logic [31:0]              ns_ff;
   logic signed [32:0]       err_ff;
   logic signed [31:0]       kp_ff, ki_ff, kd_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [63:0]       integ_new_ff, deriv_ff;
   logic signed [DIV_W-1:0]  tmp_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     neg_ff;
   logic                     rsp_valid_ff;
   logic [2:0]               rsp_ch_ff;
   logic signed [31:0]       rsp_drive_ff;
   logic                     rsp_alarm_ff, rsp_running_ff, rsp_last_ff;

   logic [IDX_W-1:0]         ci, wi;
   logic                     wr_ok;
   logic [3:0]               wr_ext;
   logic [3:0]               limit_now;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [66:0]       isum;
   logic signed [63:0]       iclamp;
   logic [DIV_W-1:0]         div_mag, div_q, rdiv_q, div_pick, sq;
   logic                     div_busy, div_start, rdiv_busy, rdiv_start;
   logic [ACC_W-1:0]         amag;
   logic [ACC_W-17:0]        ashr;
   logic [31:0]              dlim, dmag, dnext;

   assign ci        = ch_ff[IDX_W-1:0];
   assign wr_ext    = {1'b0, req_channel};
   assign wi        = wr_ext[IDX_W-1:0];
   assign wr_ok     = (32'(wr_ext) < CHANNELS);
   assign limit_now = (count_ff > 4'(CAP)) ? 4'(CAP) : count_ff;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         mpid_pkg::STEP_INT: begin
            mul_a = MUL_W'(err_ff);
            mul_b = $signed({3'b0, ns_ff});
         end
         mpid_pkg::STEP_P: begin
            mul_a = MUL_W'(err_ff);
            mul_b = MUL_W'(kp_ff);
         end
         mpid_pkg::STEP_DIFF: begin
            mul_a = MUL_W'(err_ff) - MUL_W'(prev_ff[ci]);
            mul_b = $signed({3'b0, mpid_pkg::NS_SCALE});
         end
         mpid_pkg::STEP_DLO: begin
            mul_a = $signed({3'b0, deriv_ff[31:0]});
            mul_b = MUL_W'(kd_ff);
         end
         mpid_pkg::STEP_DHI: begin
            mul_a = MUL_W'($signed(deriv_ff[63:32]));
            mul_b = MUL_W'(kd_ff);
         end
         mpid_pkg::STEP_ILO: begin
            mul_a = $signed({3'b0, integ_new_ff[31:0]});
            mul_b = MUL_W'(ki_ff);
         end
         mpid_pkg::STEP_IHI: begin
            mul_a = MUL_W'($signed(integ_new_ff[63:32]));
            mul_b = MUL_W'(ki_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // saturating integral update and output saturation
   always_comb begin
      isum = 67'(integ_ff[ci]) + 67'($signed(prod_ff[65:0]));
      if (isum[66:63] == 4'b0000 || isum[66:63] == 4'b1111) begin
         iclamp = isum[63:0];
      end else if (isum[66]) begin
         iclamp = {1'b1, 63'b0};
      end else begin
         iclamp = {1'b0, {63{1'b1}}};
      end
      amag  = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      ashr  = amag[ACC_W-1:16];
      dlim  = acc_ff[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      dmag  = (ashr > (ACC_W-16)'(dlim)) ? dlim : ashr[31:0];
      dnext = acc_ff[ACC_W-1] ? (32'd0 - dmag) : dmag;
   end

   // derivative divides by ns bit-serially, integral term by 1e9 via reciprocal
   assign div_start  = (cmd.op == mpid_pkg::OP_DIV_START) &&
                       (cmd.step == mpid_pkg::STEP_DIFF);
   assign rdiv_start = (cmd.op == mpid_pkg::OP_DIV_START) &&
                       (cmd.step != mpid_pkg::STEP_DIFF);
   assign div_mag    = tmp_ff[DIV_W-1] ? DIV_W'(-tmp_ff) : DIV_W'(tmp_ff);
   assign div_pick   = (cmd.step == mpid_pkg::STEP_DIFF) ? div_q : rdiv_q;
   assign sq         = neg_ff ? (DIV_W'(0) - div_pick) : div_pick;

   mpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .divisor  (ns_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   mpid_rdiv u_rdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (rdiv_start),
      .dividend (div_mag),
      .busy     (rdiv_busy),
      .quotient (rdiv_q)
   );

   // config and resettable stores
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 4'd8;
         dkp_ff       <= 32'sd65536;
         dki_ff       <= '0;
         dkd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            pv_ff[i]    <= '0;
            sp_ff[i]    <= '0;
            drv_ff[i]   <= '0;
            integ_ff[i] <= '0;
            prev_ff[i]  <= '0;
            en_ff[i]    <= 1'b0;
            gl_ff[i]    <= 1'b0;
            lo_ff[i]    <= 32'sh8000_0000;
            hi_ff[i]    <= 32'sh7FFF_FFFF;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               mpid_pkg::CSR_CHANNEL_COUNT: count_ff <= csr_write_data[3:0];
               mpid_pkg::CSR_GAIN_P:        dkp_ff   <= csr_write_data;
               mpid_pkg::CSR_GAIN_I:        dki_ff   <= csr_write_data;
               mpid_pkg::CSR_GAIN_D:        dkd_ff   <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.op == mpid_pkg::OP_WRITE && wr_ok) begin
            case (req_kind)
               mpid_pkg::KIND_PROCESS:  pv_ff[wi] <= req_value;
               mpid_pkg::KIND_SETPOINT: sp_ff[wi] <= req_value;
               mpid_pkg::KIND_LIMITS: begin
                  lo_ff[wi] <= req_value;
                  hi_ff[wi] <= req_high_limit;
               end
               mpid_pkg::KIND_ENABLE: begin
                  en_ff[wi] <= req_enable;
                  if (!req_enable) begin
                     integ_ff[wi] <= '0;
                     prev_ff[wi]  <= '0;
                  end
               end
               mpid_pkg::KIND_GAINS: gl_ff[wi] <= 1'b1;
               default: ;
            endcase
         end
         if (cmd.op == mpid_pkg::OP_STORE) begin
            integ_ff[ci] <= integ_new_ff;
            prev_ff[ci]  <= err_ff;
            drv_ff[ci]   <= dnext;
         end
         if (cmd.op == mpid_pkg::OP_EMIT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // gain table, undefined until written
   always_ff @(posedge clock) begin
      if (cmd.op == mpid_pkg::OP_WRITE && wr_ok && req_kind == mpid_pkg::KIND_GAINS) begin
         gp_ff[wi] <= req_gain_p;
         gi_ff[wi] <= req_gain_i;
         gd_ff[wi] <= req_gain_d;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff    <= '0;
         limit_ff <= '0;
      end else begin
         if (cmd.op == mpid_pkg::OP_TICK) begin
            ch_ff    <= '0;
            limit_ff <= limit_now;
         end else if (cmd.op == mpid_pkg::OP_EMIT) begin
            ch_ff <= ch_ff + 4'd1;
         end
      end
      case (cmd.op)
         mpid_pkg::OP_TICK: ns_ff <= req_delta_ns;
         mpid_pkg::OP_LOAD: begin
            err_ff <= 33'(sp_ff[ci]) - 33'(pv_ff[ci]);
            kp_ff  <= gl_ff[ci] ? gp_ff[ci] : dkp_ff;
            ki_ff  <= gl_ff[ci] ? gi_ff[ci] : dki_ff;
            kd_ff  <= gl_ff[ci] ? gd_ff[ci] : dkd_ff;
         end
         mpid_pkg::OP_MUL: prod_ff <= mul_a * mul_b;
         mpid_pkg::OP_ACC: begin
            case (cmd.step)
               mpid_pkg::STEP_INT:  integ_new_ff <= iclamp;
               mpid_pkg::STEP_P:    acc_ff <= ACC_W'(prod_ff);
               mpid_pkg::STEP_DIFF: tmp_ff <= DIV_W'(prod_ff);
               mpid_pkg::STEP_DLO:  acc_ff <= acc_ff + ACC_W'(prod_ff);
               mpid_pkg::STEP_DHI:  acc_ff <= acc_ff + $signed({prod_ff[65:0], 32'b0});
               mpid_pkg::STEP_ILO:  tmp_ff <= DIV_W'(prod_ff);
               mpid_pkg::STEP_IHI:  tmp_ff <= tmp_ff + $signed({prod_ff[63:0], 32'b0});
               default: ;
            endcase
         end
         mpid_pkg::OP_DIV_START: neg_ff <= tmp_ff[DIV_W-1];
         mpid_pkg::OP_DIV_TAKE: begin
            if (cmd.step == mpid_pkg::STEP_DIFF) begin
               deriv_ff <= sq[63:0];
            end else begin
               acc_ff <= acc_ff + ACC_W'($signed(sq));
            end
         end
         mpid_pkg::OP_EMIT: begin
            rsp_ch_ff      <= ch_ff[2:0];
            rsp_drive_ff   <= drv_ff[ci];
            rsp_alarm_ff   <= (pv_ff[ci] < lo_ff[ci]) || (pv_ff[ci] > hi_ff[ci]);
            rsp_running_ff <= en_ff[ci];
            rsp_last_ff    <= status.last;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.enabled    = en_ff[ci];
      status.ns_zero    = (ns_ff == '0);
      status.div_busy   = div_busy || rdiv_busy;
      status.out_free   = !rsp_valid_ff || rsp_ready;
      status.last       = (ch_ff == limit_ff - 4'd1);
      status.limit_zero = (limit_now == '0);
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_channel = rsp_ch_ff;
   assign rsp_drive_value    = rsp_drive_ff;
   assign rsp_alarm          = rsp_alarm_ff;
   assign rsp_running        = rsp_running_ff;
   assign rsp_last           = rsp_last_ff;
endmodule
`default_nettype wire

/* src/mpid_ctrl.sv */
// Controller: sequences writes and the per-channel PID steps of a tick.
`default_nettype none
module mpid_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic [2:0]           req_kind,
   output logic                      req_ready,
   input  wire mpid_pkg::status_type status,
   output mpid_pkg::cmd_type         cmd
);
   mpid_pkg::state_type state_ff, state_in;
   mpid_pkg::step_type  step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpid_pkg::ST_IDLE;
         step_ff  <= mpid_pkg::STEP_INT;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd.op    = mpid_pkg::OP_NONE;
      cmd.step  = step_ff;
      case (state_ff)
         mpid_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == mpid_pkg::KIND_TICK) begin
                  cmd.op = mpid_pkg::OP_TICK;
                  if (!status.limit_zero) state_in = mpid_pkg::ST_LOAD;
               end else if (req_kind <= mpid_pkg::KIND_GAINS) begin
                  cmd.op = mpid_pkg::OP_WRITE;
               end
            end
         end
         mpid_pkg::ST_LOAD: begin
            cmd.op   = mpid_pkg::OP_LOAD;
            step_in  = mpid_pkg::STEP_INT;
            state_in = status.enabled ? mpid_pkg::ST_MUL : mpid_pkg::ST_EMIT;
         end
         mpid_pkg::ST_MUL: begin
            cmd.op   = mpid_pkg::OP_MUL;
            state_in = mpid_pkg::ST_ACC;
         end
         mpid_pkg::ST_ACC: begin
            cmd.op   = mpid_pkg::OP_ACC;
            state_in = mpid_pkg::ST_MUL;
            case (step_ff)
               mpid_pkg::STEP_INT: step_in = mpid_pkg::STEP_P;
               mpid_pkg::STEP_P:
                  step_in = status.ns_zero ? mpid_pkg::STEP_ILO : mpid_pkg::STEP_DIFF;
               mpid_pkg::STEP_DIFF: state_in = mpid_pkg::ST_DSTART;
               mpid_pkg::STEP_DLO:  step_in = mpid_pkg::STEP_DHI;
               mpid_pkg::STEP_DHI:  step_in = mpid_pkg::STEP_ILO;
               mpid_pkg::STEP_ILO:  step_in = mpid_pkg::STEP_IHI;
               mpid_pkg::STEP_IHI:  state_in = mpid_pkg::ST_DSTART;
               default:             state_in = mpid_pkg::ST_IDLE;
            endcase
         end
         mpid_pkg::ST_DSTART: begin
            cmd.op   = mpid_pkg::OP_DIV_START;
            state_in = mpid_pkg::ST_DWAIT;
         end
         mpid_pkg::ST_DWAIT: begin
            if (!status.div_busy) begin
               cmd.op = mpid_pkg::OP_DIV_TAKE;
               if (step_ff == mpid_pkg::STEP_DIFF) begin
                  step_in  = mpid_pkg::STEP_DLO;
                  state_in = mpid_pkg::ST_MUL;
               end else begin
                  state_in = mpid_pkg::ST_STORE;
               end
            end
         end
         mpid_pkg::ST_STORE: begin
            cmd.op   = mpid_pkg::OP_STORE;
            state_in = mpid_pkg::ST_EMIT;
         end
         mpid_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = mpid_pkg::OP_EMIT;
               state_in = status.last ? mpid_pkg::ST_IDLE : mpid_pkg::ST_LOAD;
            end
         end
         default: state_in = mpid_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* tb/tb_multichannel_pid_with_limit_alarms.sv */
// Self-checking testbench for the multichannel PID block with limit alarms.
`timescale 1ns / 1ps
`default_nettype none
module tb_multichannel_pid_with_limit_alarms;
   import mpid_pkg::*;

   // Channel write or tick transaction as offered on the req_* side.
   typedef struct {
      logic [2:0]         kind;
      logic [2:0]         channel;
      logic signed [31:0] value;
      logic signed [31:0] high_limit;
      logic               enable;
      logic signed [31:0] gain_p;
      logic signed [31:0] gain_i;
      logic signed [31:0] gain_d;
      logic [31:0]        delta_ns;
   } pid_req_t;

   // One channel report of a tick.
   typedef struct {
      logic [2:0]         channel;
      logic signed [31:0] drive;
      logic               alarm;
      logic               running;
      logic               last;
   } chan_report_t;

   localparam logic signed [127:0] I64_MAX   = 128'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [127:0] I64_MIN   = -I64_MAX - 128'sd1;
   localparam logic signed [127:0] I32_MAX   = 128'sd2147483647;
   localparam logic signed [127:0] I32_MIN   = -128'sd2147483648;
   localparam logic signed [127:0] NS_PER_S  = 128'sd1000000000;
   localparam logic signed [127:0] Q16_ONE   = 128'sd65536;
   localparam int                  DRAIN_CYC = 60;   // a write or an empty tick is short
   localparam int                  LONG_HOLD = 2500; // receiver stall, covers a full tick

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_kind = '0;
   logic [2:0]         req_channel = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_high_limit = '0;
   logic               req_enable = 1'b0;
   logic signed [31:0] req_gain_p = '0;
   logic signed [31:0] req_gain_i = '0;
   logic signed [31:0] req_gain_d = '0;
   logic [31:0]        req_delta_ns = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_result_channel;
   logic signed [31:0] rsp_drive_value;
   logic               rsp_alarm;
   logic               rsp_running;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   always #5 clock = ~clock;

   multichannel_pid_with_limit_alarms u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_channel(req_channel), .req_value(req_value), .req_high_limit(req_high_limit),
      .req_enable(req_enable), .req_gain_p(req_gain_p), .req_gain_i(req_gain_i),
      .req_gain_d(req_gain_d), .req_delta_ns(req_delta_ns),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_channel(rsp_result_channel), .rsp_drive_value(rsp_drive_value),
      .rsp_alarm(rsp_alarm), .rsp_running(rsp_running), .rsp_last(rsp_last),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // ---------------------------------------------------------------
   // Mirror of the controller state, updated as transactions are accepted
   // ---------------------------------------------------------------
   logic [3:0]         cfg_count = 4'd8;
   logic signed [31:0] dflt_kp = 32'sd65536;
   logic signed [31:0] dflt_ki = '0;
   logic signed [31:0] dflt_kd = '0;

   logic signed [31:0] pv_mem    [8];
   logic signed [31:0] sp_mem    [8];
   logic signed [31:0] drive_mem [8];
   logic signed [31:0] lo_mem    [8];
   logic signed [31:0] hi_mem    [8];
   logic signed [63:0] integ_mem [8];
   logic signed [32:0] perr_mem  [8];
   logic signed [31:0] kp_mem    [8];
   logic signed [31:0] ki_mem    [8];
   logic signed [31:0] kd_mem    [8];
   bit                 en_mem    [8];
   bit                 own_gains [8];

   pid_req_t     pending_q[$];   // transactions waiting for the driver
   chan_report_t report_q[$];    // channel reports still owed by the block

   int  fail_count   = 0;
   int  tick_count   = 0;
   int  report_count = 0;
   int  csr_count    = 0;
   bit  req_busy     = 1'b0;     // driver is holding a transaction on the bus
   bit  calm         = 1'b0;     // no idling on either side
   bit  long_hold_req = 1'b0;

   initial begin
      for (int c = 0; c < 8; c++) begin
         pv_mem[c] = '0; sp_mem[c] = '0; drive_mem[c] = '0;
         integ_mem[c] = '0; perr_mem[c] = '0; en_mem[c] = 1'b0; own_gains[c] = 1'b0;
         lo_mem[c] = 32'sh8000_0000; hi_mem[c] = 32'sh7FFF_FFFF;
         kp_mem[c] = '0; ki_mem[c] = '0; kd_mem[c] = '0;
      end
   end

   // One PID update of an enabled channel, all in 128-bit exact arithmetic.
   task automatic update_loop(input int c, input logic [31:0] ns);
      logic signed [127:0] sp, pv, err, prev, nsw, integ, deriv, sum, q;
      logic signed [127:0] kp, ki, kd;
      sp   = sp_mem[c];
      pv   = pv_mem[c];
      prev = perr_mem[c];
      nsw  = {96'b0, ns};
      if (own_gains[c]) begin
         kp = kp_mem[c]; ki = ki_mem[c]; kd = kd_mem[c];
      end else begin
         kp = dflt_kp; ki = dflt_ki; kd = dflt_kd;
      end
      err   = sp - pv;
      integ = integ_mem[c];
      integ = integ + err * nsw;
      if (integ > I64_MAX) integ = I64_MAX;
      if (integ < I64_MIN) integ = I64_MIN;
      integ_mem[c] = integ[63:0];
      deriv = (ns == 0) ? 128'sd0 : ((err - prev) * NS_PER_S) / nsw;
      sum = err * kp + (integ * ki) / NS_PER_S + deriv * kd;
      q = sum / Q16_ONE;                    // truncates toward zero
      if (q > I32_MAX) q = I32_MAX;
      if (q < I32_MIN) q = I32_MIN;
      drive_mem[c] = q[31:0];
      perr_mem[c]  = err[32:0];
   endtask

   // Applies one accepted transaction and queues the reports it owes.
   task automatic apply_transaction(input pid_req_t t);
      int           n;
      chan_report_t r;
      int           ch;
      ch = t.channel;
      case (t.kind)
         KIND_PROCESS:  pv_mem[ch] = t.value;
         KIND_SETPOINT: sp_mem[ch] = t.value;
         KIND_LIMITS: begin
            lo_mem[ch] = t.value;
            hi_mem[ch] = t.high_limit;
         end
         KIND_ENABLE: begin
            en_mem[ch] = t.enable;
            if (!t.enable) begin
               integ_mem[ch] = '0;
               perr_mem[ch]  = '0;
            end
         end
         KIND_GAINS: begin
            kp_mem[ch] = t.gain_p; ki_mem[ch] = t.gain_i; kd_mem[ch] = t.gain_d;
            own_gains[ch] = 1'b1;
         end
         KIND_TICK: begin
            tick_count++;
            n = (cfg_count > 8) ? 8 : cfg_count;
            for (int c = 0; c < n; c++) begin
               if (en_mem[c]) update_loop(c, t.delta_ns);
               r.channel = c[2:0];
               r.drive   = drive_mem[c];
               r.alarm   = (pv_mem[c] < lo_mem[c]) || (pv_mem[c] > hi_mem[c]);
               r.running = en_mem[c];
               r.last    = (c + 1 == n);
               report_q.push_back(r);
            end
         end
         default: ;   // unknown kinds are dropped
      endcase
   endtask

   // ---------------------------------------------------------------
   // Driver: offers queued transactions, changes inputs on the falling edge
   // ---------------------------------------------------------------
   int req_gap = 0;
   always @(negedge clock) begin
      pid_req_t t;
      if (!reset && !req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            t = pending_q.pop_front();
            req_kind <= t.kind;        req_channel <= t.channel;
            req_value <= t.value;      req_high_limit <= t.high_limit;
            req_enable <= t.enable;    req_gain_p <= t.gain_p;
            req_gain_i <= t.gain_i;    req_gain_d <= t.gain_d;
            req_delta_ns <= t.delta_ns;
            req_valid <= 1'b1;
            req_busy = 1'b1;
            // idle burst after this transaction, now and then
            if (!calm && $urandom_range(99) < 20) req_gap = $urandom_range(19, 1);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // acceptance: the predictor runs on the edge the handshake completes
   always @(posedge clock) begin
      pid_req_t t;
      if (!reset && req_valid && req_ready) begin
         t.kind = req_kind;         t.channel = req_channel;
         t.value = req_value;       t.high_limit = req_high_limit;
         t.enable = req_enable;     t.gain_p = req_gain_p;
         t.gain_i = req_gain_i;     t.gain_d = req_gain_d;
         t.delta_ns = req_delta_ns;
         apply_transaction(t);
         req_busy = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Receiver: random stall bursts plus one long hold-off
   // ---------------------------------------------------------------
   int rsp_hold = 0;
   always @(negedge clock) begin
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         rsp_hold = LONG_HOLD;
      end else if (rsp_hold == 0 && !calm && $urandom_range(99) < 8) begin
         rsp_hold = $urandom_range(19, 1);
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: compares each report with the oldest one owed
   always @(posedge clock) begin
      chan_report_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (report_q.size() == 0) begin
            $error("unexpected report for channel %0d", rsp_result_channel);
            fail_count++;
         end else begin
            e = report_q.pop_front();
            report_count++;
            if (rsp_result_channel !== e.channel) begin
               $error("result_channel expected %0d got %0d", e.channel, rsp_result_channel);
               fail_count++;
            end
            if (rsp_drive_value !== e.drive) begin
               $error("drive_value expected %0d got %0d", e.drive, rsp_drive_value);
               fail_count++;
            end
            if (rsp_alarm !== e.alarm) begin
               $error("alarm expected %0d got %0d", e.alarm, rsp_alarm);
               fail_count++;
            end
            if (rsp_running !== e.running) begin
               $error("running expected %0d got %0d", e.running, rsp_running);
               fail_count++;
            end
            if (rsp_last !== e.last) begin
               $error("last expected %0d got %0d", e.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic pid_req_t blank_req(input logic [2:0] kind, input logic [2:0] ch);
      pid_req_t t;
      // unused fields carry noise so every bit toggles
      t.kind = kind;           t.channel = ch;
      t.value = $urandom;      t.high_limit = $urandom;
      t.enable = $urandom;     t.gain_p = $urandom;
      t.gain_i = $urandom;     t.gain_d = $urandom;
      t.delta_ns = $urandom;
      return t;
   endfunction

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return 32'(int'($urandom_range(20000)) - 10000);
      if (sel < 85) return $urandom;
      if (sel < 92) return 32'sh7FFF_FFFF;
      return 32'sh8000_0000;
   endfunction

   function automatic logic signed [31:0] pick_gain();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return 32'(int'($urandom_range(262144)) - 131072);
      if (sel < 90) return $urandom;
      return sel[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
   endfunction

   function automatic logic [31:0] pick_ns();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return $urandom_range(1000000, 1000);
      if (sel < 78) return 32'd0;
      if (sel < 84) return 32'd1;
      if (sel < 92) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // A mostly well-formed control sequence: ticks dominate, channels get
   // enabled, values move around; a few unknown kinds as noise.
   function automatic pid_req_t random_req(output bit counted);
      pid_req_t t;
      int       sel;
      sel = $urandom_range(99);
      counted = 1'b1;
      t = blank_req(KIND_TICK, $urandom_range(7));
      if (sel < 30) begin
         t.delta_ns = pick_ns();
      end else if (sel < 45) begin
         t.kind = KIND_PROCESS;  t.value = pick_value();
      end else if (sel < 58) begin
         t.kind = KIND_SETPOINT; t.value = pick_value();
      end else if (sel < 68) begin
         t.kind = KIND_LIMITS;   t.value = pick_value(); t.high_limit = pick_value();
      end else if (sel < 82) begin
         t.kind = KIND_ENABLE;   t.enable = ($urandom_range(99) < 80);
      end else if (sel < 96) begin
         t.kind = KIND_GAINS;
         t.gain_p = pick_gain(); t.gain_i = pick_gain(); t.gain_d = pick_gain();
      end else begin
         t.kind = $urandom_range(7, 6);
         counted = 1'b0;
      end
      return t;
   endfunction

   task automatic push_random(input int count);
      pid_req_t t;
      bit       counted;
      int       done;
      done = 0;
      while (done < count) begin
         t = random_req(counted);
         pending_q.push_back(t);
         if (counted) done++;
      end
   endtask

   // Waits until every transaction went in and every report came out.
   task automatic drain();
      while (pending_q.size() > 0 || req_busy || report_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
   endtask

   // Register write while idle; the mirror is updated as the write is driven.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_CHANNEL_COUNT: cfg_count = data[3:0];
         CSR_GAIN_P:        dflt_kp   = data;
         CSR_GAIN_I:        dflt_ki   = data;
         CSR_GAIN_D:        dflt_kd   = data;
         default: ;
      endcase
      csr_count++;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic push(input pid_req_t t);
      pending_q.push_back(t);
   endtask

   // ---------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------
   initial begin
      pid_req_t t;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset gains, extremes, empty/odd ticks, unknown kinds.
      t = blank_req(KIND_TICK, 0);    t.delta_ns = 32'd1000;       push(t); // all disabled
      t = blank_req(KIND_ENABLE, 0);  t.enable = 1'b1;             push(t);
      t = blank_req(KIND_ENABLE, 0);  t.enable = 1'b1;             push(t); // re-enable
      t = blank_req(KIND_SETPOINT, 0); t.value = 32'sh7FFF_FFFF;   push(t);
      t = blank_req(KIND_PROCESS, 0);  t.value = 32'sh8000_0000;   push(t); // largest error
      t = blank_req(KIND_TICK, 3);    t.delta_ns = 32'hFFFF_FFFF;  push(t);
      t = blank_req(KIND_TICK, 0);    t.delta_ns = 32'd0;          push(t); // no derivative
      t = blank_req(KIND_SETPOINT, 0); t.value = 32'sh8000_0000;   push(t);
      t = blank_req(KIND_PROCESS, 0);  t.value = 32'sh7FFF_FFFF;   push(t);
      t = blank_req(KIND_TICK, 0);    t.delta_ns = 32'd1;          push(t); // huge derivative
      t = blank_req(KIND_LIMITS, 1);  t.value = 32'sd100; t.high_limit = -32'sd100;
      push(t);                                                       // low above high
      t = blank_req(KIND_ENABLE, 7);  t.enable = 1'b1;             push(t);
      t = blank_req(KIND_GAINS, 7);
      t.gain_p = 32'sh8000_0000; t.gain_i = 32'sh7FFF_FFFF; t.gain_d = 32'sh8000_0000;
      push(t);
      t = blank_req(KIND_PROCESS, 7); t.value = 32'sd5000;          push(t);
      t = blank_req(6, 2);                                          push(t); // dropped
      t = blank_req(7, 5);                                          push(t); // dropped
      t = blank_req(KIND_TICK, 7);    t.delta_ns = 32'd12345;      push(t);
      t = blank_req(KIND_TICK, 7);    t.delta_ns = 32'd777;        push(t);
      t = blank_req(KIND_ENABLE, 0);  t.enable = 1'b0;             push(t); // clears loop
      t = blank_req(KIND_TICK, 1);    t.delta_ns = 32'd500;        push(t);
      drain();

      // Phase: all channels, PI-ish default gains, long receiver hold-off.
      csr_write(CSR_CHANNEL_COUNT, 32'd8);
      csr_write(CSR_GAIN_P, 32'sd65536);
      csr_write(CSR_GAIN_I, 32'sd32768);
      csr_write(CSR_GAIN_D, 32'sd16);
      long_hold_req = 1'b1;
      push_random(80);
      drain();

      // Phase: no channels handled, extreme default gains.
      csr_write(CSR_CHANNEL_COUNT, 32'hFFFF_FFF0);
      csr_write(CSR_GAIN_P, 32'sh8000_0000);
      csr_write(CSR_GAIN_I, 32'sh7FFF_FFFF);
      csr_write(CSR_GAIN_D, 32'sh8000_0000);
      push_random(30);
      drain();

      // Phase: count 15 is capped at eight, random defaults.
      csr_write(CSR_CHANNEL_COUNT, 32'd15);
      csr_write(CSR_GAIN_P, pick_gain());
      csr_write(CSR_GAIN_I, pick_gain());
      csr_write(CSR_GAIN_D, pick_gain());
      push_random(60);
      drain();

      // Phase: three channels, saturating proportional gain.
      csr_write(CSR_CHANNEL_COUNT, 32'd3);
      csr_write(CSR_GAIN_P, 32'sh7FFF_FFFF);
      csr_write(CSR_GAIN_I, $urandom);
      csr_write(CSR_GAIN_D, 32'sd0);
      push_random(60);
      drain();

      // Final phase: back-to-back traffic, no idling anywhere.
      csr_write(CSR_CHANNEL_COUNT, $urandom_range(9, 1));
      csr_write(CSR_GAIN_D, pick_gain());
      calm = 1'b1;
      push_random(60);
      drain();
      repeat (300) @(posedge clock);

      $display("Covered %0d ticks with %0d channel reports and %0d register writes,",
               tick_count, report_count, csr_count);
      $display("including channel counts 0, 3, 8 and 15 and saturating gains.");
      if (fail_count == 0 && report_q.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (report_q.size() != 0)
            $error("%0d channel reports never arrived", report_q.size());
         $display("TB_ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #30ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
